>>> sv/csc_pkg.sv
package csc_pkg;

    // numerator width of a divide request, signed
    localparam int NW = 40;
    // denominator width of a divide request
    localparam int DW = 26;
    // quotient bits, one per divider stage after the entry stage
    localparam int DIV_STEPS = 8;

    // color space codes
    localparam logic [2:0] SP_RGB   = 3'd0;
    localparam logic [2:0] SP_HSL   = 3'd1;
    localparam logic [2:0] SP_HSV   = 3'd2;
    localparam logic [2:0] SP_Y601  = 3'd3;
    localparam logic [2:0] SP_Y709  = 3'd4;
    localparam logic [2:0] SP_YCOCG = 3'd5;
    localparam logic [2:0] SP_CMY   = 3'd6;

    // one channel value as an exact fraction num / den
    typedef struct packed {
        logic signed [NW-1:0] num;
        logic [DW-1:0]        den;
    } t_nd;

endpackage

>>> sv/csc_div.sv
module csc_div (
    input  logic                        i_clk,
    input  logic [csc_pkg::DIV_STEPS:0] i_en,
    input  csc_pkg::t_nd                i_nd [3],
    output logic [7:0]                  o_q [3]
);

    localparam int NW = csc_pkg::NW;
    localparam int DW = csc_pkg::DW;
    localparam int NS = csc_pkg::DIV_STEPS;

    logic [NW-1:0] r_rem [0:NS-1][0:2];
    logic [DW:0]   r_dv  [0:NS-1][0:2];
    logic          r_neg [0:NS-1][0:2];
    logic          r_big [0:NS-1][0:2];
    logic [7:0]    r_qt  [0:NS][0:2];

    logic [NW-1:0] w_lim [0:2];
    logic [NW-1:0] w_dsh [1:NS][0:2];
    logic          w_ge  [1:NS][0:2];
    logic [7:0]    w_q   [1:NS][0:2];

    // saturation limit 255 * den and one trial subtract per stage
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_lim[c] = NW'({i_nd[c].den, 8'd0}) - NW'(i_nd[c].den);
            for (int k = 1; k <= NS; k++) begin
                w_dsh[k][c] = NW'(r_dv[k-1][c]) << (NS - k);
                w_ge[k][c]  = r_rem[k-1][c] >= w_dsh[k][c];
                w_q[k][c]   = r_qt[k-1][c] | (8'(w_ge[k][c]) << (NS - k));
            end
        end
    end

    // entry stage, then one quotient bit per stage, msb first
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (i_en[0]) begin
                r_neg[0][c] <= i_nd[c].num <= 0;
                r_big[0][c] <= i_nd[c].num >= $signed(w_lim[c]);
                r_rem[0][c] <= {i_nd[c].num[NW-2:0], 1'b0} + NW'(i_nd[c].den);
                r_dv[0][c]  <= {i_nd[c].den, 1'b0};
                r_qt[0][c]  <= 8'd0;
            end
            for (int k = 1; k < NS; k++) begin
                if (i_en[k]) begin
                    r_rem[k][c] <= w_ge[k][c] ? r_rem[k-1][c] - w_dsh[k][c] : r_rem[k-1][c];
                    r_dv[k][c]  <= r_dv[k-1][c];
                    r_neg[k][c] <= r_neg[k-1][c];
                    r_big[k][c] <= r_big[k-1][c];
                    r_qt[k][c]  <= w_q[k][c];
                end
            end
            if (i_en[NS]) begin
                r_qt[NS][c] <= r_neg[NS-1][c] ? 8'd0 :
                               r_big[NS-1][c] ? 8'hFF : w_q[NS][c];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            o_q[c] = r_qt[NS][c];
        end
    end

endmodule

>>> sv/color_space_converter_top.sv
// order of stages: a1, a2, divider a, b1, b2, divider b
// throughput: one pixel per clock while the output is not stalled; a stage loads
//   when empty or its successor moves; the dividers add one quotient bit per stage
// a stalled output holds its stage, bubbles ahead of it still fill
// reset clears all stage valid bits and sets both spaces to RGB
module color_space_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // chan_first, chan_second, chan_third
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_first, out_second, out_third
    output logic        m_axis_tlast
);

    localparam int NW    = csc_pkg::NW;
    localparam int DW    = csc_pkg::DW;
    localparam int ST_DA = 2;
    localparam int ST_B1 = ST_DA + csc_pkg::DIV_STEPS + 1;
    localparam int ST_B2 = ST_B1 + 1;
    localparam int ST_DB = ST_B2 + 1;
    localparam int NS    = ST_DB + csc_pkg::DIV_STEPS + 1;

    localparam logic REG_SRC = 1'b0;
    localparam logic REG_TGT = 1'b1;

    typedef struct packed {
        logic [2:0]           src;
        logic [7:0]           a;
        logic [7:0]           b;
        logic [7:0]           e;
        logic [15:0]          p;
        logic [15:0]          q;
        logic [9:0]           ur;
        logic [9:0]           ug;
        logic [9:0]           ub;
        logic [2:0]           sect;
        logic [7:0]           fn;
        logic [15:0]          be;
        logic [15:0]          vmb;
        logic signed [NW-1:0] ky;
        logic signed [NW-1:0] rcr;
        logic signed [NW-1:0] bcb;
        logic signed [NW-1:0] gy;
        logic signed [NW-1:0] gcb;
        logic signed [NW-1:0] gcr;
        logic [DW-1:0]        gden;
    } t_a1;

    typedef struct packed {
        logic [2:0]  tgt;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  mx;
        logic [7:0]  d;
        logic [8:0]  s;
        logic [10:0] n;
        logic [21:0] y;
    } t_b1;

    function automatic csc_pkg::t_nd mk_nd(input logic signed [NW-1:0] num,
                                           input logic [DW-1:0] den);
        csc_pkg::t_nd v;
        v.num = num;
        v.den = den;
        return v;
    endfunction

    function automatic logic signed [NW-1:0] zx(input logic [21:0] v);
        return $signed(NW'(v));
    endfunction

    // one hsl channel from its hue position u and the bounds p, q
    function automatic csc_pkg::t_nd hsl_nd(input logic [9:0] u,
                                            input logic [15:0] p,
                                            input logic [15:0] q);
        logic signed [NW-1:0] pp;
        logic signed [NW-1:0] dq;
        csc_pkg::t_nd v;
        pp = zx(22'(p));
        dq = zx(22'(q)) - pp;
        if (u < 10'd128) begin
            v = mk_nd(pp * 765 + dq * (zx(22'(u)) * 6), DW'(195075));
        end else if (u < 10'd383) begin
            v = mk_nd(zx(22'(q)), DW'(255));
        end else if (u < 10'd510) begin
            v = mk_nd(pp * 765 + dq * (zx(22'(10'd510 - u)) * 6), DW'(195075));
        end else begin
            v = mk_nd(pp, DW'(255));
        end
        return v;
    endfunction

    logic [2:0]    r_src;
    logic [2:0]    r_tgt;
    logic [NS-1:0] r_vld;
    logic [NS-1:0] r_last;
    logic [NS-1:0] w_en;
    logic [NS-1:0] n_vld;

    t_a1          r_a1;
    t_a1          n_a1;
    csc_pkg::t_nd r_a2 [3];
    csc_pkg::t_nd n_a2 [3];
    t_b1          r_b1;
    t_b1          n_b1;
    csc_pkg::t_nd r_b2 [3];
    csc_pkg::t_nd n_b2 [3];
    logic [7:0]   w_rgb [3];
    logic [7:0]   w_res [3];

    // config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= csc_pkg::SP_RGB;
            r_tgt <= csc_pkg::SP_RGB;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SRC: r_src <= i_cfg_data;
                REG_TGT: r_tgt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage enables: a stage loads when it is empty or its successor moves
    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld = (w_en & {r_vld[NS-2:0], s_axis_tvalid}) | (~w_en & r_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= (w_en & {r_last[NS-2:0], s_axis_tlast}) | (~w_en & r_last);
    end

    assign s_axis_tready = w_en[0];

    // stage a1: products of the input channels
    logic [7:0]           w_a, w_b, w_e;
    logic [15:0]          w_eb;
    logic [17:0]          w_q18, w_p18;
    logic [9:0]           w_3a, w_ur;
    logic [10:0]          w_6a;
    logic [2:0]           w_sec;
    logic signed [9:0]    w_cb2, w_cr2;
    logic signed [NW-1:0] w_k_rcr, w_k_bcb, w_k_gy, w_k_gcb, w_k_gcr;

    assign w_a = s_axis_tdata[7:0];
    assign w_b = s_axis_tdata[15:8];
    assign w_e = s_axis_tdata[23:16];

    always_comb begin
        w_eb = 16'(w_e) * 16'(w_b);
        if (w_e >= 8'd128) begin
            w_q18 = 18'd255 * (18'(w_e) + 18'(w_b)) - 18'(w_eb);
        end else begin
            w_q18 = 18'(w_e) * (18'd255 + 18'(w_b));
        end
        w_p18 = 18'd510 * 18'(w_e) - w_q18;

        w_3a = 10'(w_a) * 10'd3;
        w_ur = w_3a + 10'd255;
        if (w_ur > 10'd765) begin
            w_ur = w_ur - 10'd765;
        end

        w_6a = 11'(w_a) * 11'd6;
        if (w_6a >= 11'd1530)      w_sec = 3'd6;
        else if (w_6a >= 11'd1275) w_sec = 3'd5;
        else if (w_6a >= 11'd1020) w_sec = 3'd4;
        else if (w_6a >= 11'd765)  w_sec = 3'd3;
        else if (w_6a >= 11'd510)  w_sec = 3'd2;
        else if (w_6a >= 11'd255)  w_sec = 3'd1;
        else                       w_sec = 3'd0;

        w_cb2 = $signed({1'b0, w_b, 1'b0}) - 10'sd255;
        w_cr2 = $signed({1'b0, w_e, 1'b0}) - 10'sd255;
        // g row constants are scaled down by a common factor
        if (r_src == csc_pkg::SP_Y709) begin
            w_k_rcr = NW'(7874);
            w_k_bcb = NW'(9278);
            w_k_gy  = NW'(17880000);
            w_k_gcb = NW'(1674679);
            w_k_gcr = NW'(4185031);
        end else begin
            w_k_rcr = NW'(7010);
            w_k_bcb = NW'(8860);
            w_k_gy  = NW'(587000);
            w_k_gcb = NW'(101004);
            w_k_gcr = NW'(209599);
        end

        n_a1.src  = r_src;
        n_a1.a    = w_a;
        n_a1.b    = w_b;
        n_a1.e    = w_e;
        n_a1.q    = w_q18[15:0];
        n_a1.p    = w_p18[15:0];
        n_a1.ur   = w_ur;
        n_a1.ug   = w_3a;
        n_a1.ub   = (w_3a < 10'd255) ? w_3a + 10'd510 : w_3a - 10'd255;
        n_a1.sect = (w_sec == 3'd6) ? 3'd0 : w_sec;
        n_a1.fn   = 8'(w_6a - 11'(w_sec) * 11'd255);
        n_a1.be   = w_eb;
        n_a1.vmb  = 16'(8'd255 - w_b) * 16'(w_e);
        n_a1.ky   = zx(22'(w_a)) * 10000;
        n_a1.rcr  = NW'(w_cr2) * w_k_rcr;
        n_a1.bcb  = NW'(w_cb2) * w_k_bcb;
        n_a1.gy   = zx(22'(w_a)) * w_k_gy;
        n_a1.gcb  = NW'(w_cb2) * w_k_gcb;
        n_a1.gcr  = NW'(w_cr2) * w_k_gcr;
        n_a1.gden = DW'(w_k_gy);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_a1 <= n_a1;
        end
    end

    // stage a2: exact rgb fractions from the source space
    logic signed [NW-1:0] w_vf, w_vmin, w_ad;
    csc_pkg::t_nd         w_vv, w_vin, w_vde, w_vm;

    always_comb begin
        w_vf   = zx(22'(r_a1.e)) * 65025;
        w_vmin = zx(22'(r_a1.vmb)) * 255;
        w_ad   = zx(22'(r_a1.be)) * zx(22'(r_a1.fn));
        w_vv   = mk_nd(w_vf, DW'(65025));
        w_vm   = mk_nd(w_vmin, DW'(65025));
        w_vin  = mk_nd(w_vmin + w_ad, DW'(65025));
        w_vde  = mk_nd(w_vf - w_ad, DW'(65025));

        case (r_a1.src)
            csc_pkg::SP_HSL: begin
                n_a2[0] = hsl_nd(r_a1.ur, r_a1.p, r_a1.q);
                n_a2[1] = hsl_nd(r_a1.ug, r_a1.p, r_a1.q);
                n_a2[2] = hsl_nd(r_a1.ub, r_a1.p, r_a1.q);
            end
            csc_pkg::SP_HSV: begin
                case (r_a1.sect)
                    3'd0: begin n_a2[0] = w_vv;  n_a2[1] = w_vin; n_a2[2] = w_vm;  end
                    3'd1: begin n_a2[0] = w_vde; n_a2[1] = w_vv;  n_a2[2] = w_vm;  end
                    3'd2: begin n_a2[0] = w_vm;  n_a2[1] = w_vv;  n_a2[2] = w_vin; end
                    3'd3: begin n_a2[0] = w_vm;  n_a2[1] = w_vde; n_a2[2] = w_vv;  end
                    3'd4: begin n_a2[0] = w_vin; n_a2[1] = w_vm;  n_a2[2] = w_vv;  end
                    default: begin n_a2[0] = w_vv; n_a2[1] = w_vm; n_a2[2] = w_vde; end
                endcase
            end
            csc_pkg::SP_Y601, csc_pkg::SP_Y709: begin
                n_a2[0] = mk_nd(r_a1.ky + r_a1.rcr, DW'(10000));
                n_a2[1] = mk_nd(r_a1.gy - r_a1.gcb - r_a1.gcr, r_a1.gden);
                n_a2[2] = mk_nd(r_a1.ky + r_a1.bcb, DW'(10000));
            end
            csc_pkg::SP_YCOCG: begin
                n_a2[0] = mk_nd(zx(22'(r_a1.a)) + zx(22'(r_a1.b)) - zx(22'(r_a1.e)),
                                DW'(1));
                n_a2[1] = mk_nd(zx(22'(r_a1.a)) * 2 + zx(22'(r_a1.e)) * 2 - 255, DW'(2));
                n_a2[2] = mk_nd(zx(22'(r_a1.a)) - zx(22'(r_a1.b)) - zx(22'(r_a1.e)) + 255,
                                DW'(1));
            end
            csc_pkg::SP_CMY: begin
                n_a2[0] = mk_nd(255 - zx(22'(r_a1.a)), DW'(1));
                n_a2[1] = mk_nd(255 - zx(22'(r_a1.b)), DW'(1));
                n_a2[2] = mk_nd(255 - zx(22'(r_a1.e)), DW'(1));
            end
            default: begin
                n_a2[0] = mk_nd(zx(22'(r_a1.a)), DW'(1));
                n_a2[1] = mk_nd(zx(22'(r_a1.b)), DW'(1));
                n_a2[2] = mk_nd(zx(22'(r_a1.e)), DW'(1));
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_a2 <= n_a2;
        end
    end

    // rounding divider to rgb
    csc_div u_div_a (
        .i_clk (i_clk),
        .i_en  (w_en[ST_DA + csc_pkg::DIV_STEPS:ST_DA]),
        .i_nd  (r_a2),
        .o_q   (w_rgb)
    );

    // stage b1: max, min, hue numerator and luma sum
    logic [7:0]  w_mx, w_mn, w_d;
    logic [10:0] w_d11;

    always_comb begin
        w_mx = w_rgb[0];
        w_mn = w_rgb[0];
        if (w_rgb[1] > w_mx) w_mx = w_rgb[1];
        if (w_rgb[2] > w_mx) w_mx = w_rgb[2];
        if (w_rgb[1] < w_mn) w_mn = w_rgb[1];
        if (w_rgb[2] < w_mn) w_mn = w_rgb[2];
        w_d   = w_mx - w_mn;
        w_d11 = 11'(w_d);

        n_b1.tgt = r_tgt;
        n_b1.r   = w_rgb[0];
        n_b1.g   = w_rgb[1];
        n_b1.b   = w_rgb[2];
        n_b1.mx  = w_mx;
        n_b1.d   = w_d;
        n_b1.s   = 9'(w_mx) + 9'(w_mn);
        // ties go to red first, then green
        if (w_d == 8'd0) begin
            n_b1.n = 11'd0;
        end else if (w_mx == w_rgb[0]) begin
            n_b1.n = (w_rgb[1] >= w_rgb[2]) ? 11'(w_rgb[1] - w_rgb[2]) :
                     11'(w_rgb[1]) - 11'(w_rgb[2]) + 11'd6 * w_d11;
        end else if (w_mx == w_rgb[1]) begin
            n_b1.n = 11'(w_rgb[2]) - 11'(w_rgb[0]) + 11'd2 * w_d11;
        end else begin
            n_b1.n = 11'(w_rgb[0]) - 11'(w_rgb[1]) + 11'd4 * w_d11;
        end
        if (r_tgt == csc_pkg::SP_Y709) begin
            n_b1.y = 22'(w_rgb[0]) * 22'd2126 + 22'(w_rgb[1]) * 22'd7152
                   + 22'(w_rgb[2]) * 22'd722;
        end else begin
            n_b1.y = 22'(w_rgb[0]) * 22'd2990 + 22'(w_rgb[1]) * 22'd5870
                   + 22'(w_rgb[2]) * 22'd1140;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_B1]) begin
            r_b1 <= n_b1;
        end
    end

    // stage b2: exact fractions in the target space
    csc_pkg::t_nd w_hue;
    logic [8:0]   w_denl;

    always_comb begin
        if (r_b1.d == 8'd0) begin
            w_hue = mk_nd(NW'(0), DW'(1));
        end else begin
            w_hue = mk_nd(zx(22'(r_b1.n)) * 255, DW'(r_b1.d) * DW'(6));
        end
        w_denl = (r_b1.s <= 9'd255) ? r_b1.s : 9'd510 - r_b1.s;

        case (r_b1.tgt)
            csc_pkg::SP_HSL: begin
                n_b2[0] = w_hue;
                // gray pixels get zero saturation
                if (r_b1.d == 8'd0 || w_denl == 9'd0) begin
                    n_b2[1] = mk_nd(NW'(0), DW'(1));
                end else begin
                    n_b2[1] = mk_nd(zx(22'(r_b1.d)) * 255, DW'(w_denl));
                end
                n_b2[2] = mk_nd(zx(22'(r_b1.s)), DW'(2));
            end
            csc_pkg::SP_HSV: begin
                n_b2[0] = w_hue;
                if (r_b1.mx == 8'd0) begin
                    n_b2[1] = mk_nd(NW'(0), DW'(1));
                end else begin
                    n_b2[1] = mk_nd(zx(22'(r_b1.d)) * 255, DW'(r_b1.mx));
                end
                n_b2[2] = mk_nd(zx(22'(r_b1.mx)), DW'(1));
            end
            csc_pkg::SP_Y601: begin
                n_b2[0] = mk_nd(zx(r_b1.y), DW'(10000));
                n_b2[1] = mk_nd(zx(22'(r_b1.b)) * 10000 - zx(r_b1.y) + 2259300,
                                DW'(17720));
                n_b2[2] = mk_nd(zx(22'(r_b1.r)) * 10000 - zx(r_b1.y) + 1787550,
                                DW'(14020));
            end
            csc_pkg::SP_Y709: begin
                n_b2[0] = mk_nd(zx(r_b1.y), DW'(10000));
                n_b2[1] = mk_nd(zx(22'(r_b1.b)) * 10000 - zx(r_b1.y) + 2365890,
                                DW'(18556));
                n_b2[2] = mk_nd(zx(22'(r_b1.r)) * 10000 - zx(r_b1.y) + 2007870,
                                DW'(15748));
            end
            csc_pkg::SP_YCOCG: begin
                n_b2[0] = mk_nd(zx(22'(r_b1.r)) + zx(22'(r_b1.g)) * 2 + zx(22'(r_b1.b)),
                                DW'(4));
                n_b2[1] = mk_nd(zx(22'(r_b1.r)) * 2 - zx(22'(r_b1.b)) * 2 + 510, DW'(4));
                n_b2[2] = mk_nd(zx(22'(r_b1.g)) * 2 - zx(22'(r_b1.r)) - zx(22'(r_b1.b))
                                + 510, DW'(4));
            end
            csc_pkg::SP_CMY: begin
                n_b2[0] = mk_nd(255 - zx(22'(r_b1.r)), DW'(1));
                n_b2[1] = mk_nd(255 - zx(22'(r_b1.g)), DW'(1));
                n_b2[2] = mk_nd(255 - zx(22'(r_b1.b)), DW'(1));
            end
            default: begin
                n_b2[0] = mk_nd(zx(22'(r_b1.r)), DW'(1));
                n_b2[1] = mk_nd(zx(22'(r_b1.g)), DW'(1));
                n_b2[2] = mk_nd(zx(22'(r_b1.b)), DW'(1));
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_B2]) begin
            r_b2 <= n_b2;
        end
    end

    // rounding divider to the target space, its last stage is the output register
    csc_div u_div_b (
        .i_clk (i_clk),
        .i_en  (w_en[ST_DB + csc_pkg::DIV_STEPS:ST_DB]),
        .i_nd  (r_b2),
        .o_q   (w_res)
    );

    assign m_axis_tvalid = r_vld[NS-1];
    assign m_axis_tdata  = {w_res[2], w_res[1], w_res[0]};
    assign m_axis_tlast  = r_last[NS-1];

    // full pipeline behind a stalled output takes no new request
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld && !m_axis_tready) |-> !s_axis_tready)
        else $error("request taken while pipeline full and stalled");

    // an empty pipeline always takes a request
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld == '0) |-> s_axis_tready)
        else $error("empty pipeline not ready");

    // an accepted request occupies the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_vld[0])
        else $error("accepted request lost at entry");

    // reset leaves no result on the output
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

>>> tb/sv/tb_color_space_converter_top.sv
module tb_color_space_converter_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       last;
        logic [7:0] c2;
        logic [7:0] c1;
        logic [7:0] c0;
    } t_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [2:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    localparam int LATENCY = 22;
    localparam int WATCHDOG_LIMIT = 2000;

    color_space_converter_top u_top (.*);

    always #5 i_clk = ~i_clk;

    // model state
    logic [2:0] src_space = csc_pkg::SP_RGB;
    logic [2:0] dst_space = csc_pkg::SP_RGB;

    t_pixel pending_pixels[$];
    t_pixel expected_pixels[$];
    int     num_errors = 0;
    int     num_results = 0;
    int     idle_cycles = 0;

    // clamp to 0..255 and round half away from zero
    function automatic longint sat_div(longint num, longint den);
        if (num <= 0) return 0;
        if (num >= 255 * den) return 255;
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic longint hue_calc(longint r, longint g, longint b,
                                        longint mx, longint mn);
        longint d, n;
        d = mx - mn;
        if (d == 0) return 0;
        if (mx == r) n = (g >= b) ? (g - b) : (g - b + 6 * d);
        else if (mx == g) n = b - r + 2 * d;
        else n = r - g + 4 * d;
        return sat_div(255 * n, 6 * d);
    endfunction

    function automatic longint hsl_level(longint u, longint p, longint q);
        if (2 * u < 255) return sat_div(p * 765 + (q - p) * 6 * u, 765 * 255);
        if (2 * u < 765) return sat_div(q, 255);
        if (u < 510) return sat_div(p * 765 + (q - p) * 6 * (510 - u), 765 * 255);
        return sat_div(p, 255);
    endfunction

    // converts one pixel source space -> rgb -> target space
    function automatic t_pixel convert_pixel(t_pixel px);
        longint a, b, e, r, g, bl, mx, mn, kr, kg, kb, y;
        longint q, p, sec, fn, vf, vmin, ad, vin, vde, vv, vm, s, d, den;
        t_pixel res;
        a = px.c0; b = px.c1; e = px.c2;
        r = a; g = b; bl = e;
        // to rgb
        case (src_space)
            csc_pkg::SP_HSL: begin
                q = (e >= 128) ? 255 * (e + b) - e * b : e * (255 + b);
                p = 2 * e * 255 - q;
                r = 3 * a + 255;
                if (r > 765) r -= 765;
                bl = 3 * a - 255;
                if (bl < 0) bl += 765;
                r = hsl_level(r, p, q);
                g = hsl_level(3 * a, p, q);
                bl = hsl_level(bl, p, q);
            end
            csc_pkg::SP_HSV: begin
                sec = (6 * a) / 255;
                fn = 6 * a - 255 * sec;
                vf = e * 65025;
                vmin = (255 - b) * e * 255;
                ad = b * e * fn;
                vin = sat_div(vmin + ad, 65025);
                vde = sat_div(vf - ad, 65025);
                vv = sat_div(vf, 65025);
                vm = sat_div(vmin, 65025);
                case (sec % 6)
                    0: begin r = vv; g = vin; bl = vm; end
                    1: begin r = vde; g = vv; bl = vm; end
                    2: begin r = vm; g = vv; bl = vin; end
                    3: begin r = vm; g = vde; bl = vv; end
                    4: begin r = vin; g = vm; bl = vv; end
                    default: begin r = vv; g = vm; bl = vde; end
                endcase
            end
            csc_pkg::SP_Y601, csc_pkg::SP_Y709: begin
                if (src_space == csc_pkg::SP_Y601) begin
                    kr = 2990; kg = 5870; kb = 1140;
                end else begin
                    kr = 2126; kg = 7152; kb = 722;
                end
                r = sat_div(10000 * a + (10000 - kr) * (2 * e - 255), 10000);
                g = sat_div(10000 * kg * a - kb * (10000 - kb) * (2 * b - 255)
                            - kr * (10000 - kr) * (2 * e - 255), 10000 * kg);
                bl = sat_div(10000 * a + (10000 - kb) * (2 * b - 255), 10000);
            end
            csc_pkg::SP_YCOCG: begin
                r = sat_div(a + b - e, 1);
                g = sat_div(2 * a + 2 * e - 255, 2);
                bl = sat_div(a - b - e + 255, 1);
            end
            csc_pkg::SP_CMY: begin
                r = 255 - a; g = 255 - b; bl = 255 - e;
            end
            default: ;
        endcase
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (bl > mx) mx = bl;
        if (g < mn) mn = g;
        if (bl < mn) mn = bl;
        a = r; b = g; e = bl;
        // from rgb
        case (dst_space)
            csc_pkg::SP_HSL: begin
                s = mx + mn;
                d = mx - mn;
                den = (s <= 255) ? s : 510 - s;
                a = hue_calc(r, g, bl, mx, mn);
                b = (d == 0 || den <= 0) ? 0 : sat_div(255 * d, den);
                e = (s + 1) / 2;
            end
            csc_pkg::SP_HSV: begin
                a = hue_calc(r, g, bl, mx, mn);
                b = (mx == 0) ? 0 : sat_div(255 * (mx - mn), mx);
                e = mx;
            end
            csc_pkg::SP_Y601, csc_pkg::SP_Y709: begin
                if (dst_space == csc_pkg::SP_Y601) begin
                    kr = 2990; kg = 5870; kb = 1140;
                end else begin
                    kr = 2126; kg = 7152; kb = 722;
                end
                y = kr * r + kg * g + kb * bl;
                a = sat_div(y, 10000);
                b = sat_div(10000 * bl - y + 255 * (10000 - kb), 2 * (10000 - kb));
                e = sat_div(10000 * r - y + 255 * (10000 - kr), 2 * (10000 - kr));
            end
            csc_pkg::SP_YCOCG: begin
                a = sat_div(r + 2 * g + bl, 4);
                b = sat_div(2 * r - 2 * bl + 510, 4);
                e = sat_div(2 * g - r - bl + 510, 4);
            end
            csc_pkg::SP_CMY: begin
                a = 255 - r; b = 255 - g; e = 255 - bl;
            end
            default: ;
        endcase
        res.c0 = a[7:0];
        res.c1 = b[7:0];
        res.c2 = e[7:0];
        res.last = px.last;
        return res;
    endfunction

    // pixel driver with random gaps
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_axis_tvalid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
            t_pixel px;
            px = pending_pixels.pop_front();
            expected_pixels.push_back(convert_pixel(px));
            s_axis_tdata <= {px.c2, px.c1, px.c0};
            s_axis_tlast <= px.last;
            s_axis_tvalid <= 1'b1;
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // result monitor with random stalls
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                t_pixel got, want;
                int     stall_draw;
                got = {m_axis_tlast, m_axis_tdata};
                num_results++;
                if (expected_pixels.size() == 0) begin
                    $error("unexpected result %h", got);
                    num_errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.c0 !== want.c0) begin
                        $error("out_first expected %0d actual %0d", want.c0, got.c0);
                        num_errors++;
                    end
                    if (got.c1 !== want.c1) begin
                        $error("out_second expected %0d actual %0d", want.c1, got.c1);
                        num_errors++;
                    end
                    if (got.c2 !== want.c2) begin
                        $error("out_third expected %0d actual %0d", want.c2, got.c2);
                        num_errors++;
                    end
                    if (got.last !== want.last) begin
                        $error("last_out expected %0d actual %0d", want.last, got.last);
                        num_errors++;
                    end
                end
                stall_draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
                stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
                m_axis_tready <= (stall_draw == 0);
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on accepted requests, results and config writes
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("color_space_converter_top test failed");
            $finish;
        end
    end

    task automatic push_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] e, logic l);
        t_pixel px;
        px.c0 = a; px.c1 = b; px.c2 = e; px.last = l;
        pending_pixels.push_back(px);
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() > 0 || expected_pixels.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_space(logic idx, logic [2:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx) dst_space = val; else src_space = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        int n;
        logic [7:0] v;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pixels under reset spaces: extremes, gray, black, hue ties
        push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        push_pixel(8'd128, 8'd128, 8'd128, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd0, 1'b0);
        push_pixel(8'd0, 8'd255, 8'd255, 1'b1);
        wait_drained();

        // sweep every pair of space codes, unused code included
        for (int s = 0; s < 8; s++) begin
            for (int t = 0; t < 8; t++) begin
                write_space(1'b0, s[2:0]);
                write_space(1'b1, t[2:0]);
                push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
                push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
                push_pixel(8'd255, 8'd0, 8'd0, 1'b0);
                push_pixel(8'd0, 8'd255, 8'd0, 1'b0);
                push_pixel(8'd0, 8'd0, 8'd255, 1'b1);
                push_pixel(8'd170, 8'd255, 8'd128, 1'b0);
                push_pixel(8'd255, 8'd128, 8'd127, 1'b1);
                n = 14;
                for (int i = 0; i < n; i++) begin
                    v = $urandom_range(0, 4) == 0 ? 8'd77 : 8'($urandom);
                    if ($urandom_range(0, 3) == 0)
                        push_pixel(v, v, v, 1'($urandom));
                    else
                        push_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
                end
                wait_drained();
            end
        end

        wait_drained();
        $display("covered all 64 source/target space pairs, %0d pixels checked",
                 num_results);
        $display("random gaps and stalls on both stream sides, tlast toggled");
        if (num_errors == 0)
            $display("color_space_converter_top test passed");
        else
            $display("color_space_converter_top test failed");
        $finish;
    end

endmodule
